// ===== rtl/kpwdg_pkg.sv =====
package kpwdg_pkg;

  localparam int unsigned BaseDivide = 4;
  localparam int unsigned CountBits  = 12;
  localparam int unsigned DataBits   = 16;
  localparam int unsigned SelBits    = 2;

  // widest divide is BaseDivide << 3; the stored count stays below it
  localparam int unsigned MaxDivide  = BaseDivide << 3;
  localparam int unsigned PsBits     = (MaxDivide > 1) ? $clog2(MaxDivide) : 1;

  localparam logic [DataBits-1:0]  KeyStart  = 16'hCCCC;
  localparam logic [DataBits-1:0]  KeyFeed   = 16'hAAAA;
  localparam logic [DataBits-1:0]  KeyUnlock = 16'h5555;
  localparam logic [CountBits-1:0] CountOnes = {CountBits{1'b1}};

  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpWrite = 2'd1,
    OpRead  = 2'd2,
    OpNone  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RegKey    = 2'd0,
    RegPresc  = 2'd1,
    RegReload = 2'd2,
    RegStatus = 2'd3
  } reg_e;

  typedef struct packed {
    logic [DataBits-1:0] read_data;
    logic                expired;
  } result_t;

endpackage

// ===== rtl/key_protected_watchdog_top.sv =====
// Key protected watchdog: key, prescaler, reload and status registers.
// Input stream: one transfer is a watchdog clock tick, a bus write or a
// bus read. s_axis_tuser carries the operation and register select,
// s_axis_tdata the write data.
// Output stream: exactly one transfer per input transfer, in order.
// m_axis_tdata is the read data (zero for ticks, writes and reads of key or
// status), m_axis_tuser[0] is the expiry flag, a watchdog reset request.
// The result is valid in the output register in the cycle after the input
// transfer. Throughput: one item per cycle while the output is not stalled;
// the whole update is a single pass of logic between the watchdog state and the output register.
// Reset: watchdog stopped, registers locked, prescaler 0, reload and count
// all ones, output register empty.
// Stall: while a result waits and m_axis_tready is low, s_axis_tready drops;
// an item is taken in the same cycle the waiting result is transferred.
module key_protected_watchdog_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // write_data[15:0]
  input  logic [3:0]  s_axis_tuser,  // op[1:0], reg_sel[3:2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // read_data[15:0]
  output logic [0:0]  m_axis_tuser   // expired[0]
);

  logic               accept;
  kpwdg_pkg::result_t result;
  kpwdg_pkg::result_t out_q;
  logic               out_valid_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  kpwdg_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .op_i         (kpwdg_pkg::op_e'(s_axis_tuser[1:0])),
    .reg_sel_i    (kpwdg_pkg::reg_e'(s_axis_tuser[3:2])),
    .write_data_i (s_axis_tdata),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) out_q <= result;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.read_data;
  assign m_axis_tuser  = out_q.expired;

  a_expire_only_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (s_axis_tuser[1:0] != kpwdg_pkg::OpTick) |=> !m_axis_tuser[0])
    else $error("expiry flagged on a non-tick transfer");

  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (s_axis_tuser[1:0] != kpwdg_pkg::OpRead) |=> m_axis_tdata == '0)
    else $error("nonzero read data on a non-read transfer");

  a_key_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (s_axis_tuser[3:2] == kpwdg_pkg::RegKey ||
               s_axis_tuser[3:2] == kpwdg_pkg::RegStatus) |=> m_axis_tdata == '0)
    else $error("key or status read returned nonzero");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

endmodule

// ===== rtl/kpwdg_core.sv =====
module kpwdg_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  kpwdg_pkg::op_e                    op_i,
  input  kpwdg_pkg::reg_e                   reg_sel_i,
  input  logic [kpwdg_pkg::DataBits-1:0]    write_data_i,
  output kpwdg_pkg::result_t                result_o
);

  logic                                  running_q, running_d;
  logic                                  unlocked_q, unlocked_d;
  logic [kpwdg_pkg::SelBits-1:0]         presc_sel_q, presc_sel_d;
  logic [kpwdg_pkg::CountBits-1:0]       reload_q, reload_d;
  logic [kpwdg_pkg::PsBits-1:0]          ps_cnt_q, ps_cnt_d;
  logic [kpwdg_pkg::CountBits-1:0]       down_q, down_d;

  logic [kpwdg_pkg::PsBits:0]            ps_inc;
  logic [kpwdg_pkg::PsBits:0]            divide;

  assign ps_inc = {1'b0, ps_cnt_q} + {{kpwdg_pkg::PsBits{1'b0}}, 1'b1};
  assign divide = (kpwdg_pkg::PsBits+1)'(kpwdg_pkg::BaseDivide) << presc_sel_q;

  always_comb begin
    running_d   = running_q;
    unlocked_d  = unlocked_q;
    presc_sel_d = presc_sel_q;
    reload_d    = reload_q;
    ps_cnt_d    = ps_cnt_q;
    down_d      = down_q;
    result_o    = '0;
    case (op_i)
      kpwdg_pkg::OpTick: begin
        if (running_q) begin
          if (ps_inc < divide) begin
            ps_cnt_d = ps_inc[kpwdg_pkg::PsBits-1:0];
          end else begin
            ps_cnt_d = '0;
            // count of one or zero expires and reloads
            if (down_q <= kpwdg_pkg::CountBits'(1)) begin
              down_d           = reload_q;
              result_o.expired = 1'b1;
            end else begin
              down_d = down_q - kpwdg_pkg::CountBits'(1);
            end
          end
        end
      end
      kpwdg_pkg::OpWrite: begin
        case (reg_sel_i)
          kpwdg_pkg::RegKey: begin
            if (write_data_i == kpwdg_pkg::KeyStart) begin
              running_d  = 1'b1;
              down_d     = reload_q;
              ps_cnt_d   = '0;
              unlocked_d = 1'b0;
            end else if (write_data_i == kpwdg_pkg::KeyFeed) begin
              down_d     = reload_q;
              unlocked_d = 1'b0;
            end else if (write_data_i == kpwdg_pkg::KeyUnlock) begin
              unlocked_d = 1'b1;
            end else begin
              unlocked_d = 1'b0;
            end
          end
          kpwdg_pkg::RegPresc: begin
            if (unlocked_q) presc_sel_d = write_data_i[kpwdg_pkg::SelBits-1:0];
          end
          kpwdg_pkg::RegReload: begin
            if (unlocked_q) reload_d = write_data_i[kpwdg_pkg::CountBits-1:0];
          end
          default: ;
        endcase
      end
      kpwdg_pkg::OpRead: begin
        case (reg_sel_i)
          kpwdg_pkg::RegPresc:
            result_o.read_data = kpwdg_pkg::DataBits'(presc_sel_q);
          kpwdg_pkg::RegReload:
            result_o.read_data = kpwdg_pkg::DataBits'(reload_q);
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      unlocked_q  <= 1'b0;
      presc_sel_q <= '0;
      reload_q    <= kpwdg_pkg::CountOnes;
      ps_cnt_q    <= '0;
      down_q      <= kpwdg_pkg::CountOnes;
    end else if (accept_i) begin
      running_q   <= running_d;
      unlocked_q  <= unlocked_d;
      presc_sel_q <= presc_sel_d;
      reload_q    <= reload_d;
      ps_cnt_q    <= ps_cnt_d;
      down_q      <= down_d;
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;

  localparam int unsigned StallLimit = 1000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // write_data[15:0]
  logic [3:0]  s_axis_tuser = '0;   // op[1:0], reg_sel[3:2]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // read_data[15:0]
  logic [0:0]  m_axis_tuser;        // expired[0]

  key_protected_watchdog_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // shadow of the watchdog state
  logic                            wd_running   = 1'b0;
  logic                            wd_unlocked  = 1'b0;
  logic [1:0]                      wd_presc     = '0;
  logic [kpwdg_pkg::CountBits-1:0] wd_reload    = kpwdg_pkg::CountOnes;
  logic [kpwdg_pkg::PsBits-1:0]    wd_presc_cnt = '0;
  logic [kpwdg_pkg::CountBits-1:0] wd_count     = kpwdg_pkg::CountOnes;

  kpwdg_pkg::result_t awaited_results[$];
  int      errors      = 0;
  int      items_sent  = 0;
  bit      idle_on     = 1'b1;
  int      stall_count = 0;

  function automatic kpwdg_pkg::result_t apply_watchdog_item(kpwdg_pkg::op_e op,
                                                             kpwdg_pkg::reg_e sel,
                                                             logic [15:0] data);
    kpwdg_pkg::result_t res;
    int unsigned        divide;
    res = '0;
    divide = kpwdg_pkg::BaseDivide << wd_presc;
    case (op)
      kpwdg_pkg::OpTick: begin
        if (wd_running) begin
          if (wd_presc_cnt + 1 < divide) begin
            wd_presc_cnt = wd_presc_cnt + 1'b1;
          end else begin
            wd_presc_cnt = '0;
            if (wd_count <= 1) begin
              wd_count = wd_reload;
              res.expired = 1'b1;
            end else begin
              wd_count = wd_count - 1'b1;
            end
          end
        end
      end
      kpwdg_pkg::OpWrite: begin
        case (sel)
          kpwdg_pkg::RegKey: begin
            if (data == kpwdg_pkg::KeyStart) begin
              wd_running = 1'b1;
              wd_count = wd_reload;
              wd_presc_cnt = '0;
              wd_unlocked = 1'b0;
            end else if (data == kpwdg_pkg::KeyFeed) begin
              wd_count = wd_reload;
              wd_unlocked = 1'b0;
            end else begin
              wd_unlocked = (data == kpwdg_pkg::KeyUnlock);
            end
          end
          kpwdg_pkg::RegPresc:  if (wd_unlocked) wd_presc = data[1:0];
          kpwdg_pkg::RegReload: if (wd_unlocked) wd_reload = data[kpwdg_pkg::CountBits-1:0];
          default: ;
        endcase
      end
      kpwdg_pkg::OpRead: begin
        if (sel == kpwdg_pkg::RegPresc) res.read_data = 16'(wd_presc);
        else if (sel == kpwdg_pkg::RegReload) res.read_data = 16'(wd_reload);
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH @%0t: %s", $time, what);
    errors++;
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= !idle_on || ($urandom_range(99) >= 8);
  end

  // predict on input transfers, check on output transfers
  always @(posedge clk_i) begin
    kpwdg_pkg::result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        awaited_results.push_back(
          apply_watchdog_item(kpwdg_pkg::op_e'(s_axis_tuser[1:0]),
                              kpwdg_pkg::reg_e'(s_axis_tuser[3:2]),
                              s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result transfer with no item pending");
        end else begin
          want = awaited_results.pop_front();
          if (m_axis_tdata !== want.read_data)
            report_mismatch($sformatf("read_data %h, expected %h",
                                      m_axis_tdata, want.read_data));
          if (m_axis_tuser[0] !== want.expired)
            report_mismatch($sformatf("expired %b, expected %b",
                                      m_axis_tuser[0], want.expired));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_count <= 0;
      end else if (stall_count >= StallLimit) begin
        $display("Timeout: no transfer for %0d cycles", StallLimit);
        $display("Test completed with failures");
        $finish;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

  task automatic send_item(kpwdg_pkg::op_e op, kpwdg_pkg::reg_e sel, logic [15:0] data);
    while (idle_on && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {sel, op};
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic test_reset_values();
    send_item(kpwdg_pkg::OpRead, kpwdg_pkg::RegKey, 16'h0000);
    send_item(kpwdg_pkg::OpRead, kpwdg_pkg::RegPresc, 16'hFFFF);
    send_item(kpwdg_pkg::OpRead, kpwdg_pkg::RegReload, 16'h0000);
    send_item(kpwdg_pkg::OpRead, kpwdg_pkg::RegStatus, 16'h0000);
    send_item(kpwdg_pkg::OpTick, kpwdg_pkg::RegKey, 16'h0000);   // stopped: nothing moves
  endtask

  task automatic test_write_lock();
    send_item(kpwdg_pkg::OpWrite, kpwdg_pkg::RegPresc, 16'hFFFF);   // locked, dropped
    send_item(kpwdg_pkg::OpWrite, kpwdg_pkg::RegReload, 16'h0000);  // locked, dropped
    send_item(kpwdg_pkg::OpRead, kpwdg_pkg::RegReload, 16'h0000);
    send_item(kpwdg_pkg::OpWrite, kpwdg_pkg::RegKey, kpwdg_pkg::KeyUnlock);
    send_item(kpwdg_pkg::OpWrite, kpwdg_pkg::RegPresc, 16'hFFFF);
    send_item(kpwdg_pkg::OpRead, kpwdg_pkg::RegPresc, 16'h0000);
    send_item(kpwdg_pkg::OpWrite, kpwdg_pkg::RegKey, 16'h0000);     // any other key relocks
    send_item(kpwdg_pkg::OpWrite, kpwdg_pkg::RegReload, 16'h0123);
  endtask

  task automatic test_zero_reload();
    send_item(kpwdg_pkg::OpWrite, kpwdg_pkg::RegKey, kpwdg_pkg::KeyUnlock);
    send_item(kpwdg_pkg::OpWrite, kpwdg_pkg::RegPresc, 16'h0000);
    send_item(kpwdg_pkg::OpWrite, kpwdg_pkg::RegReload, 16'hF000);  // low bits zero
    send_item(kpwdg_pkg::OpWrite, kpwdg_pkg::RegKey, kpwdg_pkg::KeyStart);
    repeat (8) send_item(kpwdg_pkg::OpTick, kpwdg_pkg::RegKey, 16'h0000);
  endtask

  task automatic test_odd_accesses();
    send_item(kpwdg_pkg::OpWrite, kpwdg_pkg::RegStatus, 16'hFFFF);
    send_item(kpwdg_pkg::OpNone, kpwdg_pkg::RegStatus, 16'hFFFF);
    send_item(kpwdg_pkg::OpWrite, kpwdg_pkg::RegKey, kpwdg_pkg::KeyFeed);
  endtask

  task automatic send_noise_item();
    logic [15:0] data;
    case ($urandom_range(7))
      0: data = kpwdg_pkg::KeyStart;
      1: data = kpwdg_pkg::KeyFeed;
      2: data = kpwdg_pkg::KeyUnlock;
      default: data = 16'($urandom_range(16'hFFFF));
    endcase
    send_item(kpwdg_pkg::op_e'($urandom_range(3)), kpwdg_pkg::reg_e'($urandom_range(3)), data);
  endtask

  // unlock, set prescaler and reload, start or feed, then a run of ticks mixed with reads and feeds
  task automatic send_config_and_run();
    int unsigned psel;
    int unsigned rld;
    int unsigned pick;
    int unsigned ticks;
    pick = $urandom_range(99);
    psel = (pick < 60) ? 0 : (pick < 85) ? 1 : (pick < 95) ? 2 : 3;
    pick = $urandom_range(99);
    rld = (pick < 70) ? $urandom_range(6) : (pick < 90) ? $urandom_range(40, 7)
                                                        : $urandom_range(kpwdg_pkg::CountOnes);
    send_item(kpwdg_pkg::OpWrite, kpwdg_pkg::RegKey, kpwdg_pkg::KeyUnlock);
    send_item(kpwdg_pkg::OpWrite, kpwdg_pkg::RegPresc,
              {14'($urandom_range(16'h3FFF)), 2'(psel)});
    send_item(kpwdg_pkg::OpWrite, kpwdg_pkg::RegReload, {4'($urandom_range(15)), 12'(rld)});
    if ($urandom_range(3) == 0) begin
      send_item(kpwdg_pkg::OpRead, kpwdg_pkg::RegPresc, 16'($urandom_range(16'hFFFF)));
      send_item(kpwdg_pkg::OpRead, kpwdg_pkg::RegReload, 16'($urandom_range(16'hFFFF)));
    end
    send_item(kpwdg_pkg::OpWrite, kpwdg_pkg::RegKey,
              $urandom_range(1) ? kpwdg_pkg::KeyStart : kpwdg_pkg::KeyFeed);
    ticks = $urandom_range(80, 8);
    repeat (ticks) begin
      pick = $urandom_range(99);
      if (pick < 85)
        send_item(kpwdg_pkg::OpTick, kpwdg_pkg::reg_e'($urandom_range(3)),
                  16'($urandom_range(16'hFFFF)));
      else if (pick < 95)
        send_item(kpwdg_pkg::OpRead, kpwdg_pkg::reg_e'($urandom_range(3)), 16'h0000);
      else
        send_item(kpwdg_pkg::OpWrite, kpwdg_pkg::RegKey, kpwdg_pkg::KeyFeed);
    end
  endtask

  // lock broken before the register write lands
  task automatic send_broken_unlock();
    logic [15:0] key;
    key = 16'($urandom_range(16'hFFFF));
    if (key == kpwdg_pkg::KeyUnlock) key = ~key;
    send_item(kpwdg_pkg::OpWrite, kpwdg_pkg::RegKey, kpwdg_pkg::KeyUnlock);
    send_item(kpwdg_pkg::OpWrite, kpwdg_pkg::RegKey, key);
    send_item(kpwdg_pkg::OpWrite, kpwdg_pkg::reg_e'($urandom_range(2, 1)),
              16'($urandom_range(16'hFFFF)));
    send_item(kpwdg_pkg::OpRead, kpwdg_pkg::reg_e'($urandom_range(2, 1)), 16'h0000);
  endtask

  task automatic test_random_traffic(int count);
    int target;
    int unsigned pick;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 75) send_config_and_run();
      else if (pick < 85) send_broken_unlock();
      else repeat ($urandom_range(12, 1)) send_noise_item();
    end
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    test_random_traffic(200);
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_write_lock();
    test_zero_reload();
    test_odd_accesses();
    test_random_traffic(350);
    test_full_rate();
    test_random_traffic(300);
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
